[rtl/e2q_pkg.sv]
package e2q_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int OUT_BITS = 16;
  localparam int STEPS = 31;
  localparam int CW = 33;
  localparam int ZW = 35;
  localparam logic signed [CW-1:0] GAIN = 33'sd652032874;
  localparam logic signed [CW-1:0] ONE_Q30 = 33'sd1073741824;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } rot_t;

  typedef struct packed {
    rot_t roll;
    rot_t pitch;
    rot_t yaw;
  } trio_t;

  function automatic logic signed [ZW-1:0] atan_of(input int i);
    logic [31:0] t;
    case (i)
      0: t = 32'd536870912;   1: t = 32'd316933406;  2: t = 32'd167458907;
      3: t = 32'd85004756;    4: t = 32'd42667331;   5: t = 32'd21354465;
      6: t = 32'd10679838;    7: t = 32'd5340245;    8: t = 32'd2670163;
      9: t = 32'd1335087;     10: t = 32'd667544;    11: t = 32'd333772;
      12: t = 32'd166886;     13: t = 32'd83443;     14: t = 32'd41722;
      15: t = 32'd20861;      16: t = 32'd10430;     17: t = 32'd5215;
      18: t = 32'd2608;       19: t = 32'd1304;      20: t = 32'd652;
      21: t = 32'd326;        22: t = 32'd163;       23: t = 32'd81;
      24: t = 32'd41;         25: t = 32'd20;        26: t = 32'd10;
      27: t = 32'd5;          28: t = 32'd3;         default: t = 32'd1;
    endcase
    return signed'({2'b00, t, 1'b0});
  endfunction

endpackage

[rtl/e2q_cell.sv]
module e2q_cell (
  input  logic clk,
  input  logic en,
  input  logic [4:0] step,
  input  e2q_pkg::trio_t d,
  output e2q_pkg::trio_t q
);
  import e2q_pkg::*;

  function automatic rot_t rot(input rot_t r);
    rot_t o;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    dx = r.y >>> step;
    dy = r.x >>> step;
    if (!r.z[ZW-1]) begin
      o.x = r.x - dx;
      o.y = r.y + dy;
      o.z = r.z - atan_of(int'(step));
    end else begin
      o.x = r.x + dx;
      o.y = r.y - dy;
      o.z = r.z + atan_of(int'(step));
    end
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      q.roll <= rot(d.roll);
      q.pitch <= rot(d.pitch);
      q.yaw <= rot(d.yaw);
    end
  end
endmodule

[rtl/e2q_mix.sv]
module e2q_mix (
  input  logic clk,
  input  logic en,
  input  e2q_pkg::trio_t d,
  output logic signed [e2q_pkg::OUT_BITS-1:0] qw,
  output logic signed [e2q_pkg::OUT_BITS-1:0] qx,
  output logic signed [e2q_pkg::OUT_BITS-1:0] qy,
  output logic signed [e2q_pkg::OUT_BITS-1:0] qz
);
  import e2q_pkg::*;

  localparam int PW = 2 * CW;
  localparam int SH = 31 - OUT_BITS;

  typedef logic signed [CW-1:0] v_t;

  function automatic v_t clampu(input v_t v);
    if (v > ONE_Q30) return ONE_Q30;
    if (v < -ONE_Q30) return -ONE_Q30;
    return v;
  endfunction

  function automatic v_t rnd(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    t = (p + (PW'(1) <<< 29)) >>> 30;
    return t[CW-1:0];
  endfunction

  function automatic logic signed [OUT_BITS-1:0] to_out(input logic signed [CW+1:0] v);
    logic signed [CW+1:0] t;
    if (SH > 0) t = (v + ((CW+2)'(1) <<< (SH > 0 ? SH - 1 : 0))) >>> SH;
    else if (SH == 0) t = v;
    else t = v <<< (SH < 0 ? -SH : 0);
    if (t > (CW+2)'((64'sd1 <<< (OUT_BITS-1)) - 1)) return {1'b0, {(OUT_BITS-1){1'b1}}};
    if (t < -(CW+2)'(64'sd1 <<< (OUT_BITS-1))) return {1'b1, {(OUT_BITS-1){1'b0}}};
    return t[OUT_BITS-1:0];
  endfunction

  v_t cr, sr, cp, sp, cy, sy;
  v_t crcp, srsp, srcp, crsp, cy2, sy2;
  v_t t0, t1, t2, t3, t4, t5, t6, t7;

  always_ff @(posedge clk) begin
    if (en) begin
      cr <= clampu(d.roll.x);  sr <= clampu(d.roll.y);
      cp <= clampu(d.pitch.x); sp <= clampu(d.pitch.y);
      cy <= clampu(d.yaw.x);   sy <= clampu(d.yaw.y);
      crcp <= rnd(PW'(cr) * PW'(cp));
      srsp <= rnd(PW'(sr) * PW'(sp));
      srcp <= rnd(PW'(sr) * PW'(cp));
      crsp <= rnd(PW'(cr) * PW'(sp));
      cy2 <= cy;
      sy2 <= sy;
      t0 <= rnd(PW'(crcp) * PW'(cy2));
      t1 <= rnd(PW'(srsp) * PW'(sy2));
      t2 <= rnd(PW'(srcp) * PW'(cy2));
      t3 <= rnd(PW'(crsp) * PW'(sy2));
      t4 <= rnd(PW'(crsp) * PW'(cy2));
      t5 <= rnd(PW'(srcp) * PW'(sy2));
      t6 <= rnd(PW'(crcp) * PW'(sy2));
      t7 <= rnd(PW'(srsp) * PW'(cy2));
      qw <= to_out((CW+2)'(t0) + (CW+2)'(t1));
      qx <= to_out((CW+2)'(t2) - (CW+2)'(t3));
      qy <= to_out((CW+2)'(t4) + (CW+2)'(t5));
      qz <= to_out((CW+2)'(t6) - (CW+2)'(t7));
    end
  end
endmodule

[rtl/euler_to_quaternion.sv]
// Euler (ZYX) to unit quaternion.
// s_axis: tdata = {yaw_angle, pitch_angle, roll_angle} from bit 0 up: roll
//   [15:0], pitch [31:16], yaw [47:32]; binary angles, 65536 counts per turn.
// m_axis: tdata = quat_w [15:0], quat_x [31:16], quat_y [47:32], quat_z [63:48],
//   Q1.15 fractions, +1.0 saturated to the largest code.
// One item per cycle sustained while the output is not stalled. From accept
// to tvalid an item passes 31 CORDIC cells (one rotation each, all three
// angles side by side), then clamp, two product stages, and the final
// sum/round/saturate in the output register.
// The whole pipe advances as one; when m_axis_tready is low and the output
// holds a result, the pipe freezes and s_axis_tready drops, so nothing is
// lost. With the output empty the input is never blocked; bubbles inside the
// pipe are not squeezed out.
// Reset (rst, synchronous) clears all stage valid bits; data is not cleared.
module euler_to_quaternion (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // roll, pitch, yaw
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // quat_w, quat_x, quat_y, quat_z
);
  import e2q_pkg::*;

  localparam int NV = STEPS + 4;

  logic [NV-1:0] vld;
  logic en;
  trio_t chain [STEPS+1];
  trio_t head;
  logic signed [OUT_BITS-1:0] qw, qx, qy, qz;

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[NV-1];

  // half angle: full turn of the input maps to 2^32 of a 2^33 turn
  function automatic rot_t seed(input logic [ANGLE_BITS-1:0] a);
    rot_t r;
    r.x = GAIN;
    r.y = '0;
    r.z = ZW'(signed'(a)) <<< (32 - ANGLE_BITS);
    return r;
  endfunction

  always_comb begin
    head.roll = seed(s_axis_tdata[15:0]);
    head.pitch = seed(s_axis_tdata[31:16]);
    head.yaw = seed(s_axis_tdata[47:32]);
  end
  assign chain[0] = head;

  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    e2q_cell u_cell (
      .clk(clk), .en(en), .step(5'(i)), .d(chain[i]), .q(chain[i+1])
    );
  end

  e2q_mix u_mix (
    .clk(clk), .en(en), .d(chain[STEPS]),
    .qw(qw), .qx(qx), .qy(qy), .qz(qz)
  );

  assign m_axis_tdata = {qz, qy, qx, qw};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NV-2:0], s_axis_tvalid};
    end
  end

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> vld[0])
    else $error("accepted item not tracked");
`endif
endmodule

[tb/sv/tb_top.sv]
module tb_top;
  import e2q_pkg::*;

  localparam int LATENCY = 35;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_RANDOM = 1950;
  localparam int N_CALM = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // roll [15:0], pitch [31:16], yaw [47:32]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // quat_w [15:0], quat_x, quat_y, quat_z [63:48]

  euler_to_quaternion dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------- quaternion predictor ----------------
  const longint atan_steps[31] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1};

  function automatic longint clamp_one(longint v);
    longint one;
    one = 64'sd1 <<< 30;
    if (v > one) return one;
    if (v < -one) return -one;
    return v;
  endfunction

  function automatic void half_cossin(logic [ANGLE_BITS-1:0] ang,
                                      output longint c, output longint s);
    longint x, y, z, dx, dy;
    x = 652032874;
    y = 0;
    z = longint'($signed(ang)) <<< (32 - ANGLE_BITS);
    for (int i = 0; i < 31; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= 2 * atan_steps[i];
      end else begin
        x += dx; y -= dy; z += 2 * atan_steps[i];
      end
    end
    c = clamp_one(x);
    s = clamp_one(y);
  endfunction

  function automatic longint rnd_q30(longint p);
    return (p + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint triple(longint a, longint b, longint c);
    return rnd_q30(rnd_q30(a * b) * c);
  endfunction

  function automatic logic [OUT_BITS-1:0] q30_to_out(longint q);
    longint v;
    longint hi, lo;
    hi = (64'sd1 <<< (OUT_BITS - 1)) - 1;
    lo = -(64'sd1 <<< (OUT_BITS - 1));
    v = (q + (64'sd1 <<< (30 - OUT_BITS))) >>> (31 - OUT_BITS);
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[OUT_BITS-1:0];
  endfunction

  function automatic logic [63:0] quat_of_euler(logic [47:0] angles);
    longint cr, sr, cp, sp, cy, sy;
    logic [15:0] w, x, y, z;
    half_cossin(angles[15:0], cr, sr);
    half_cossin(angles[31:16], cp, sp);
    half_cossin(angles[47:32], cy, sy);
    w = q30_to_out(triple(cr, cp, cy) + triple(sr, sp, sy));
    x = q30_to_out(triple(sr, cp, cy) - triple(cr, sp, sy));
    y = q30_to_out(triple(cr, sp, cy) + triple(sr, cp, sy));
    z = q30_to_out(triple(cr, cp, sy) - triple(sr, sp, cy));
    return {z, y, x, w};
  endfunction

  // ---------------- scoreboard ----------------
  class quat_scoreboard;
    logic [63:0] expected_quats[$];
    int mismatches = 0;
    int checked = 0;

    function void note_angles(logic [47:0] angles);
      expected_quats.insert(expected_quats.size(), quat_of_euler(angles));
    endfunction

    function void check_quat(logic [63:0] got);
      logic [63:0] want;
      bit bad;
      if (expected_quats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item %h", got);
        return;
      end
      want = expected_quats.pop_front();
      checked++;
      bad = 0;
      for (int f = 0; f < 4; f++)
        if (want[16*f +: 16] !== got[16*f +: 16]) bad = 1;
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch #%0d: w/x/y/z expected %h %h %h %h got %h %h %h %h",
                   checked, want[15:0], want[31:16], want[47:32], want[63:48],
                   got[15:0], got[31:16], got[47:32], got[63:48]);
      end
    endfunction
  endclass

  quat_scoreboard sb = new();

  int  cycles = 0;
  bit  calm = 0;        // no idling on either side
  bit  hold_req = 0;    // ask receiver for a long stall
  int  hold_left = 0;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && s_axis_tvalid && s_axis_tready) sb.note_angles(s_axis_tdata);

  always @(posedge clk)
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_quat(m_axis_tdata);

  // receiver: random stall bursts, one long hold-off on request
  int stall_left = 0;
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (calm) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // valid stays high between back-to-back items; lowered for a gap, in go_quiet and at the end
  task automatic send_angles(logic [47:0] angles);
    int gap;
    gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= angles;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic go_quiet();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_quats.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'h4000 ^ 16'($urandom_range(0, 3));
      4: return 16'hc000 ^ 16'($urandom_range(0, 3));
      default: return 16'($urandom());
    endcase
  endfunction

  logic [15:0] corner[8] = '{16'h0000, 16'h7fff, 16'h8000, 16'h0001,
                             16'hffff, 16'h4000, 16'hc000, 16'h2000};

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: every corner angle on roll, corners 1 to 4 on pitch and yaw, then all-equal triples
    for (int k = 0; k < 8; k++)
      send_angles({16'h0000, 16'h0000, corner[k]});
    for (int k = 1; k < 5; k++) begin
      send_angles({16'h0000, corner[k], 16'h0000});
      send_angles({corner[k], 16'h0000, 16'h0000});
    end
    for (int k = 1; k < 5; k++)
      send_angles({corner[k], corner[k], corner[k]});
    go_quiet();

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 400) hold_req = 1;
      if (n == 900) go_quiet();
      if (n == N_RANDOM - N_CALM) calm = 1;
      send_angles({pick_angle(), pick_angle(), pick_angle()});
    end
    s_axis_tvalid <= 1'b0;

    while (sb.expected_quats.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);

    $display("covered %0d quaternions: corner angles, half-turn codes, random triples,",
             sb.checked);
    $display("input and output stalls, one long output hold-off and a full drain");
    if (sb.mismatches == 0 && sb.expected_quats.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("tb_top: FAIL");
    end
    $finish;
  end
endmodule

[sim.f]
rtl/e2q_pkg.sv
rtl/e2q_cell.sv
rtl/e2q_mix.sv
rtl/euler_to_quaternion.sv
tb/sv/tb_top.sv
